// File: hw/rtl/fisheye_equidistant_project_assert.svh
// assertion macros shared by the checker
`ifndef FISHEYE_EQUIDISTANT_PROJECT_ASSERT_SVH
`define FISHEYE_EQUIDISTANT_PROJECT_ASSERT_SVH
// a condition holds on every clock edge out of reset
`define FEP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// an antecedent implies a consequent in the next cycle
`define FEP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: hw/rtl/fep_pkg.sv
package fep_pkg;
  localparam int unsigned CordicSteps = 24;
  localparam logic [3:0] RegFocalX  = 4'd0;
  localparam logic [3:0] RegFocalY  = 4'd1;
  localparam logic [3:0] RegCenterX = 4'd2;
  localparam logic [3:0] RegCenterY = 4'd3;
  localparam logic [3:0] RegDistK1  = 4'd4;
  localparam logic [3:0] RegDistK2  = 4'd5;
  localparam logic [3:0] RegDistK3  = 4'd6;
  localparam logic [3:0] RegDistK4  = 4'd7;

  typedef struct packed {
    logic [19:0]        focal_x;
    logic [19:0]        focal_y;
    logic [19:0]        center_x;
    logic [19:0]        center_y;
    logic signed [23:0] k1;
    logic signed [23:0] k2;
    logic signed [23:0] k3;
    logic signed [23:0] k4;
  } cfg_t;

  // truncated atan(2^-i) in Q0.30
  function automatic logic [29:0] atan_lut(input logic [4:0] i);
    logic [29:0] a;
    case (i)
      5'd0: a = 30'd843314856;  5'd1: a = 30'd497837829;
      5'd2: a = 30'd263043836;  5'd3: a = 30'd133525158;
      5'd4: a = 30'd67021686;   5'd5: a = 30'd33543515;
      5'd6: a = 30'd16775850;   5'd7: a = 30'd8388437;
      5'd8: a = 30'd4194282;    5'd9: a = 30'd2097149;
      5'd10: a = 30'd1048575;   5'd11: a = 30'd524287;
      5'd12: a = 30'd262143;    5'd13: a = 30'd131071;
      5'd14: a = 30'd65535;     5'd15: a = 30'd32767;
      5'd16: a = 30'd16383;     5'd17: a = 30'd8191;
      5'd18: a = 30'd4095;      5'd19: a = 30'd2047;
      5'd20: a = 30'd1023;      5'd21: a = 30'd511;
      5'd22: a = 30'd255;       5'd23: a = 30'd127;
      default: a = '0;
    endcase
    return a;
  endfunction
endpackage

// File: hw/rtl/fisheye_equidistant_project.sv
// channel   | signals                          | transfer
// config    | cfg_we_i cfg_idx_i cfg_data_i    | cfg_we_i high at clock edge
// point in  | plane_u_i plane_v_i              | start_i high and busy_o low
// pixel out | pixel_u_o pixel_v_o clipped_o    | done_o high, one cycle
// one point enters per clock; busy_o is always low
// pipeline order: input register, sqrt, cordic, polynomial, divider, pixel
// reset clears valid bits and restores the register defaults
// results cannot be held off, so nothing stalls
module fisheye_equidistant_project (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [23:0] plane_u_i,
  input  logic [23:0] plane_v_i,
  output logic        done_o,
  output logic [23:0] pixel_u_o,
  output logic [23:0] pixel_v_o,
  output logic        clipped_o
);
  import fep_pkg::*;

  cfg_t cfg_q;
  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.focal_x <= 20'd128000; cfg_q.focal_y <= 20'd128000;
      cfg_q.center_x <= 20'd81920; cfg_q.center_y <= 20'd61440;
      cfg_q.k1 <= '0; cfg_q.k2 <= '0; cfg_q.k3 <= '0; cfg_q.k4 <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegFocalX:  cfg_q.focal_x  <= cfg_data_i[19:0];
        RegFocalY:  cfg_q.focal_y  <= cfg_data_i[19:0];
        RegCenterX: cfg_q.center_x <= cfg_data_i[19:0];
        RegCenterY: cfg_q.center_y <= cfg_data_i[19:0];
        RegDistK1:  cfg_q.k1 <= cfg_data_i;
        RegDistK2:  cfg_q.k2 <= cfg_data_i;
        RegDistK3:  cfg_q.k3 <= cfg_data_i;
        RegDistK4:  cfg_q.k4 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // input register and squared radius
  logic in_vld_q;
  logic signed [23:0] u_q, v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_vld_q <= 1'b0;
    else in_vld_q <= start_i;
  end
  always_ff @(posedge clk_i) begin
    u_q <= plane_u_i;
    v_q <= plane_v_i;
  end
  logic [48:0] s;
  assign s = 49'(u_q * u_q) + 49'(v_q * v_q);

  logic sq_vld, co_vld, po_vld, dv_vld;
  logic [24:0] sq_r, co_r, po_r;
  logic [47:0] sq_side, co_side, po_side, dv_side;
  logic [24:0] co_t;
  logic signed [49:0] po_td;
  logic signed [31:0] dv_scale;

  fep_sqrt u_sqrt (.clk_i, .rst_ni, .valid_i(in_vld_q), .s_i(s), .side_i({u_q, v_q}),
    .valid_o(sq_vld), .r_o(sq_r), .side_o(sq_side));
  fep_cordic u_cordic (.clk_i, .rst_ni, .valid_i(sq_vld), .r_i(sq_r), .side_i(sq_side),
    .valid_o(co_vld), .t_o(co_t), .r_o(co_r), .side_o(co_side));
  fep_poly u_poly (.clk_i, .rst_ni, .cfg_i(cfg_q), .valid_i(co_vld), .t_i(co_t),
    .r_i(co_r), .side_i(co_side), .valid_o(po_vld), .thetad_o(po_td), .r_o(po_r),
    .side_o(po_side));
  fep_div u_div (.clk_i, .rst_ni, .valid_i(po_vld), .thetad_i(po_td), .r_i(po_r),
    .side_i(po_side), .valid_o(dv_vld), .scale_o(dv_scale), .side_o(dv_side));
  fep_pixel u_pixel (.clk_i, .rst_ni, .cfg_i(cfg_q), .valid_i(dv_vld), .scale_i(dv_scale),
    .side_i(dv_side), .valid_o(done_o), .pixel_u_o, .pixel_v_o, .clipped_o);
endmodule

// File: hw/rtl/fep_sqrt.sv
// pipelined integer square root, one result bit per stage
module fep_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [48:0] s_i,
  input  logic [47:0] side_i,
  output logic        valid_o,
  output logic [24:0] r_o,
  output logic [47:0] side_o
);
  import fep_pkg::*;
  localparam int unsigned N = 25;

  logic [N:0]      vld_q;
  logic [49:0]     rem_q  [N+1];
  logic [24:0]     root_q [N+1];
  logic [49:0]     s_q    [N+1];
  logic [47:0]     side_q [N+1];

  always_comb begin
    vld_q[0]  = valid_i;
    rem_q[0]  = '0;
    root_q[0] = '0;
    s_q[0]    = {1'b0, s_i};
    side_q[0] = side_i;
  end

  // restoring digit recurrence, two radicand bits per stage
  for (genvar g = 0; g < N; g++) begin : g_stage
    logic [49:0] rem_d;
    logic [49:0] trial;
    always_comb begin
      rem_d = {rem_q[g][47:0], s_q[g][49:48]};
      trial = {23'd0, root_q[g], 2'b01};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else begin
        vld_q[g+1] <= vld_q[g];
      end
    end
    always_ff @(posedge clk_i) begin
      s_q[g+1]    <= {s_q[g][47:0], 2'b00};
      side_q[g+1] <= side_q[g];
      if (rem_d >= trial) begin
        rem_q[g+1]  <= rem_d - trial;
        root_q[g+1] <= {root_q[g][23:0], 1'b1};
      end else begin
        rem_q[g+1]  <= rem_d;
        root_q[g+1] <= {root_q[g][23:0], 1'b0};
      end
    end
  end

  assign valid_o = vld_q[N];
  assign r_o     = root_q[N];
  assign side_o  = side_q[N];
endmodule

// File: hw/rtl/fep_cordic.sv
// pipelined cordic vectoring, one micro-rotation per stage
module fep_cordic (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [24:0] r_i,
  input  logic [47:0] side_i,
  output logic        valid_o,
  output logic [24:0] t_o,
  output logic [24:0] r_o,
  output logic [47:0] side_o
);
  import fep_pkg::*;
  localparam int unsigned N = CordicSteps;

  logic [N:0]          vld_q;
  logic signed [35:0]  x_q [N+1];
  logic signed [35:0]  y_q [N+1];
  logic signed [33:0]  z_q [N+1];
  logic [24:0]         r_q [N+1];
  logic [47:0]         side_q [N+1];

  always_comb begin
    vld_q[0]  = valid_i;
    x_q[0]    = 36'sd268435456;
    y_q[0]    = $signed({3'b000, r_i, 8'd0});
    z_q[0]    = '0;
    r_q[0]    = r_i;
    side_q[0] = side_i;
  end

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic signed [35:0] xs;
    logic signed [35:0] ys;
    logic signed [33:0] az;
    always_comb begin
      xs = x_q[g] >>> g;
      ys = y_q[g] >>> g;
      az = $signed({4'd0, atan_lut(5'(g))});
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else begin
        vld_q[g+1] <= vld_q[g];
      end
    end
    always_ff @(posedge clk_i) begin
      r_q[g+1]    <= r_q[g];
      side_q[g+1] <= side_q[g];
      if (!y_q[g][35]) begin
        x_q[g+1] <= x_q[g] + ys;
        y_q[g+1] <= y_q[g] - xs;
        z_q[g+1] <= z_q[g] + az;
      end else begin
        x_q[g+1] <= x_q[g] - ys;
        y_q[g+1] <= y_q[g] + xs;
        z_q[g+1] <= z_q[g] - az;
      end
    end
  end

  // clamp at zero, then drop to q.24 (angle reaches past 1.0)
  logic [33:0] zc;
  assign zc      = z_q[N][33] ? 34'd0 : z_q[N];
  assign valid_o = vld_q[N];
  assign t_o     = zc[30:6];
  assign r_o     = r_q[N];
  assign side_o  = side_q[N];
endmodule

// File: hw/rtl/fep_poly.sv
// distortion polynomial: powers, weighted sum, thetad
module fep_poly (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fep_pkg::cfg_t      cfg_i,
  input  logic               valid_i,
  input  logic [24:0]        t_i,
  input  logic [24:0]        r_i,
  input  logic [47:0]        side_i,
  output logic               valid_o,
  output logic signed [49:0] thetad_o,
  output logic [24:0]        r_o,
  output logic [47:0]        side_o
);
  import fep_pkg::*;

  logic [6:0]  vld_q;
  logic [24:0] t_q [7];
  logic [24:0] r_q [7];
  logic [47:0] side_q [7];
  logic [25:0] t2_q, t2b_q, t2c_q;
  logic [26:0] t4_q, t4c_q;
  logic [27:0] t6_q;
  logic [28:0] t8_q;
  logic signed [53:0] p1_q, p2_q, p3_q, p4_q;
  logic signed [55:0] sum_q;
  logic signed [31:0] poly_q;
  logic signed [57:0] td_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[5:0], valid_i};
    end
  end

  // stage chain: t2, t4, t6/t8, products, sum, poly, thetad
  logic [49:0] m0;
  logic [51:0] m1;
  logic [52:0] m2;
  logic [53:0] m3;
  assign m0 = t_i * t_i;
  assign m1 = t2_q * t2_q;
  assign m2 = t4_q * t2b_q;
  assign m3 = t4_q * t4_q;
  always_ff @(posedge clk_i) begin
    t_q[0] <= t_i;  r_q[0] <= r_i;  side_q[0] <= side_i;
    for (int i = 1; i < 7; i++) begin
      t_q[i] <= t_q[i-1]; r_q[i] <= r_q[i-1]; side_q[i] <= side_q[i-1];
    end
    t2_q  <= 26'(m0 >> 24);
    t4_q  <= 27'(m1 >> 24);
    t2b_q <= t2_q;
    t6_q  <= 28'(m2 >> 24);
    t8_q  <= 29'(m3 >> 24);
    t2c_q <= t2b_q;
    t4c_q <= t4_q;
    p1_q  <= cfg_i.k1 * $signed({1'b0, t2c_q});
    p2_q  <= cfg_i.k2 * $signed({1'b0, t4c_q});
    p3_q  <= cfg_i.k3 * $signed({1'b0, t6_q});
    p4_q  <= cfg_i.k4 * $signed({1'b0, t8_q});
    sum_q <= 56'(p1_q) + 56'(p2_q) + 56'(p3_q) + 56'(p4_q);
    poly_q <= 32'sd16777216 + 32'(sum_q >>> 22);
    td_q  <= $signed({1'b0, t_q[5]}) * poly_q;
  end

  assign valid_o  = vld_q[6];
  assign thetad_o = 50'(td_q >>> 24);
  assign r_o      = r_q[6];
  assign side_o   = side_q[6];
endmodule

// File: hw/rtl/fep_div.sv
// pipelined restoring divider for scale, one quotient bit per stage
module fep_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [49:0] thetad_i,
  input  logic [24:0]        r_i,
  input  logic [47:0]        side_i,
  output logic               valid_o,
  output logic signed [31:0] scale_o,
  output logic [47:0]        side_o
);
  import fep_pkg::*;
  localparam int unsigned N = 70;

  logic [N:0]   vld_q;
  logic [69:0]  num_q [N+1];
  logic [25:0]  rem_q [N+1];
  logic [69:0]  quo_q [N+1];
  logic [24:0]  r_q   [N+1];
  logic [N:0]   neg_q;
  logic [N:0]   zero_q;
  logic [47:0]  side_q [N+1];
  logic [69:0]  mag;

  assign mag = thetad_i[49] ? 70'(-(70'(thetad_i) <<< 20)) : 70'(70'(thetad_i) <<< 20);

  always_comb begin
    vld_q[0] = valid_i; num_q[0] = mag; rem_q[0] = '0; quo_q[0] = '0;
    r_q[0] = r_i; neg_q[0] = thetad_i[49]; zero_q[0] = (r_i == '0);
    side_q[0] = side_i;
  end

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic [25:0] rd;
    assign rd = {rem_q[g][24:0], num_q[g][69]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else begin
        vld_q[g+1] <= vld_q[g];
      end
    end
    always_ff @(posedge clk_i) begin
      num_q[g+1] <= {num_q[g][68:0], 1'b0};
      r_q[g+1] <= r_q[g]; neg_q[g+1] <= neg_q[g]; zero_q[g+1] <= zero_q[g];
      side_q[g+1] <= side_q[g];
      if (rd >= {1'b0, r_q[g]}) begin
        rem_q[g+1] <= rd - {1'b0, r_q[g]};
        quo_q[g+1] <= {quo_q[g][68:0], 1'b1};
      end else begin
        rem_q[g+1] <= rd;
        quo_q[g+1] <= {quo_q[g][68:0], 1'b0};
      end
    end
  end

  // sign, saturation and the zero radius case
  logic [69:0] q;
  always_comb begin
    q = quo_q[N];
    if (zero_q[N]) scale_o = 32'sd16777216;
    else if (!neg_q[N]) scale_o = (q > 70'h7FFFFFFF) ? 32'h7FFFFFFF : 32'(q);
    else scale_o = (q > 70'h80000000) ? 32'h80000000 : 32'(-q);
  end
  assign valid_o = vld_q[N];
  assign side_o  = side_q[N];
endmodule

// File: hw/rtl/fep_pixel.sv
// pixel mapping for both axes with saturation
module fep_pixel (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fep_pkg::cfg_t      cfg_i,
  input  logic               valid_i,
  input  logic signed [31:0] scale_i,
  input  logic [47:0]        side_i,
  output logic               valid_o,
  output logic [23:0]        pixel_u_o,
  output logic [23:0]        pixel_v_o,
  output logic               clipped_o
);
  import fep_pkg::*;

  logic [2:0] vld_q;
  logic signed [55:0] pu_q, pv_q;
  logic signed [52:0] au_q, av_q;
  logic [19:0] cu_q, cv_q;
  logic signed [23:0] ou_q, ov_q;
  logic cl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  function automatic logic signed [24:0] sat(input logic signed [52:0] a);
    logic signed [32:0] p;
    p = 33'(a >>> 20);
    if (p > 33'sd8388607) return {1'b1, 24'h7FFFFF};
    if (p < -33'sd8388608) return {1'b1, 24'h800000};
    return {1'b0, p[23:0]};
  endfunction

  logic signed [24:0] su, sv;
  assign su = sat(au_q);
  assign sv = sat(av_q);

  always_ff @(posedge clk_i) begin
    pu_q <= $signed(side_i[47:24]) * scale_i;
    pv_q <= $signed(side_i[23:0]) * scale_i;
    au_q <= 53'(32'(pu_q >>> 24) * $signed({1'b0, cfg_i.focal_x})) +
            53'($signed({1'b0, cfg_i.center_x, 20'd0}));
    av_q <= 53'(32'(pv_q >>> 24) * $signed({1'b0, cfg_i.focal_y})) +
            53'($signed({1'b0, cfg_i.center_y, 20'd0}));
    ou_q <= su[23:0];
    ov_q <= sv[23:0];
    cl_q <= su[24] | sv[24];
  end

  assign valid_o   = vld_q[2];
  assign pixel_u_o = ou_q;
  assign pixel_v_o = ov_q;
  assign clipped_o = cl_q;
endmodule

// File: hw/rtl/fep_checker.sv
// port level checks
module fep_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [23:0] pixel_u_o,
  input logic [23:0] pixel_v_o,
  input logic        clipped_o
);
`include "fisheye_equidistant_project_assert.svh"
  localparam int unsigned Latency = 130;
  // pipeline never refuses a point
  `FEP_ASSERT_ALWAYS(a_never_busy, !busy_o, "busy raised")
  // a result carries known values
  `FEP_ASSERT_ALWAYS(a_out_known, !done_o || !$isunknown({pixel_u_o, pixel_v_o, clipped_o}), "unknown result")
  // every result comes from a transfer made the pipeline latency earlier
  `FEP_ASSERT_ALWAYS(a_done_src, !done_o || $past(start_i && !busy_o, Latency), "result without point")
  // every transfer yields its result after the pipeline latency
  `FEP_ASSERT_NEXT(a_done_due, $past(start_i && !busy_o, Latency - 1), done_o, "result missing")
endmodule

bind fisheye_equidistant_project fep_checker u_fep_checker (.*);

// File: sim/fisheye_equidistant_project_tb.sv
module fisheye_equidistant_project_tb;
  import fep_pkg::*;

  localparam logic [3:0] RegSpare = 4'd9;   // beyond the register list, ignored
  localparam int unsigned WatchLimit = 5000;
  localparam int unsigned DrainCycles = 200;

  typedef struct packed {
    logic [23:0] pix_u;
    logic [23:0] pix_v;
    logic        clip;
  } pixel_t;

  // expected pixels and the lens model that produces them
  class pixel_scoreboard;
    cfg_t   lens;
    pixel_t pending_q[$];
    int     errors;
    longint atan_steps[24] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287,
      262143, 131071, 65535, 32767, 16383, 8191,
      4095, 2047, 1023, 511, 255, 127};

    function void lens_defaults();
      lens = '{focal_x: 20'd128000, focal_y: 20'd128000, center_x: 20'd81920,
               center_y: 20'd61440, k1: '0, k2: '0, k3: '0, k4: '0};
    endfunction

    function void set_reg(logic [3:0] idx, logic [23:0] data);
      case (idx)
        RegFocalX:  lens.focal_x  = data[19:0];
        RegFocalY:  lens.focal_y  = data[19:0];
        RegCenterX: lens.center_x = data[19:0];
        RegCenterY: lens.center_y = data[19:0];
        RegDistK1:  lens.k1 = data;
        RegDistK2:  lens.k2 = data;
        RegDistK3:  lens.k3 = data;
        RegDistK4:  lens.k4 = data;
        default: ;
      endcase
    endfunction

    // scaled coordinate times focal length plus centre, saturated to Q15.8
    function logic [23:0] place(longint p, longint scale, longint f, longint c,
                                inout logic clip);
      longint us, pix;
      us  = (p * scale) >>> 24;
      pix = (us * f + c * (longint'(1) << 20)) >>> 20;
      if (pix > 8388607) begin
        pix = 8388607; clip = 1'b1;
      end
      if (pix < -8388608) begin
        pix = -8388608; clip = 1'b1;
      end
      return pix[23:0];
    endfunction

    function pixel_t project(logic [23:0] pu, logic [23:0] pv);
      longint u, v, s, r, cand, x, y, z, xs, ys;
      longint t, t2, t4, t6, t8, sum, poly, thetad, scale;
      pixel_t res;
      logic clip;
      u = $signed(pu);
      v = $signed(pv);
      s = u * u + v * v;
      // floor square root, one bit at a time
      r = 0;
      for (int b = 23; b >= 0; b--) begin
        cand = r | (longint'(1) << b);
        if (cand * cand <= s) r = cand;
      end
      if (r == 0) begin
        scale = longint'(1) << 24;
      end else begin
        // vectoring rotation gives atan(r / 2^20)
        x = longint'(1) << 28; y = r << 8; z = 0;
        for (int i = 0; i < 24; i++) begin
          xs = x >>> i; ys = y >>> i;
          if (y >= 0) begin
            x += ys; y -= xs; z += atan_steps[i];
          end else begin
            x -= ys; y += xs; z -= atan_steps[i];
          end
        end
        if (z < 0) z = 0;
        t  = z >>> 6;
        t2 = (t * t) >>> 24;
        t4 = (t2 * t2) >>> 24;
        t6 = (t4 * t2) >>> 24;
        t8 = (t4 * t4) >>> 24;
        sum = longint'(lens.k1) * t2 + longint'(lens.k2) * t4
            + longint'(lens.k3) * t6 + longint'(lens.k4) * t8;
        poly   = (longint'(1) << 24) + (sum >>> 22);
        thetad = (t * poly) >>> 24;
        scale  = (thetad * (longint'(1) << 20)) / r;
        if (scale > 64'sd2147483647) scale = 64'sd2147483647;
        if (scale < -64'sd2147483648) scale = -64'sd2147483648;
      end
      clip = 1'b0;
      res.pix_u = place(u, scale, longint'(lens.focal_x), longint'(lens.center_x), clip);
      res.pix_v = place(v, scale, longint'(lens.focal_y), longint'(lens.center_y), clip);
      res.clip  = clip;
      return res;
    endfunction

    function void note_point(logic [23:0] pu, logic [23:0] pv);
      pending_q.push_back(project(pu, pv));
    endfunction

    function void check_pixel(logic [23:0] pu, logic [23:0] pv, logic clip);
      pixel_t exp_px;
      if (pending_q.size() == 0) begin
        $error("pixel result with none expected: %h %h %b", pu, pv, clip);
        errors++;
        return;
      end
      exp_px = pending_q.pop_front();
      if (pu !== exp_px.pix_u) begin
        $error("pixel_u expected %h actual %h", exp_px.pix_u, pu); errors++;
      end
      if (pv !== exp_px.pix_v) begin
        $error("pixel_v expected %h actual %h", exp_px.pix_v, pv); errors++;
      end
      if (clip !== exp_px.clip) begin
        $error("clipped expected %b actual %b", exp_px.clip, clip); errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [3:0]  cfg_idx_i;
  logic [23:0] cfg_data_i;
  logic        start_i;
  logic        busy_o;
  logic [23:0] plane_u_i;
  logic [23:0] plane_v_i;
  logic        done_o;
  logic [23:0] pixel_u_o;
  logic [23:0] pixel_v_o;
  logic        clipped_o;

  pixel_scoreboard sb;
  int unsigned     quiet_cycles;
  int unsigned     idle_pct;

  fisheye_equidistant_project i_dut (.*);

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  // transfer monitor, register mirror and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.set_reg(cfg_idx_i, cfg_data_i);
      if (start_i && !busy_o) sb.note_point(plane_u_i, plane_v_i);
      if (done_o) sb.check_pixel(pixel_u_o, pixel_v_o, clipped_o);
      if ((start_i && !busy_o) || done_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchLimit) begin
        $display("fisheye_equidistant_project_tb NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_point(logic [23:0] u, logic [23:0] v);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i   <= 1'b1;
    plane_u_i <= u;
    plane_v_i <= v;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // sender holds off until every pixel is back
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [23:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_lens(logic [23:0] fx, logic [23:0] fy, logic [23:0] cx,
                            logic [23:0] cy, logic [23:0] k1, logic [23:0] k2,
                            logic [23:0] k3, logic [23:0] k4);
    write_reg(RegFocalX, fx);
    write_reg(RegFocalY, fy);
    write_reg(RegCenterX, cx);
    write_reg(RegCenterY, cy);
    write_reg(RegDistK1, k1);
    write_reg(RegDistK2, k2);
    write_reg(RegDistK3, k3);
    write_reg(RegDistK4, k4);
    write_reg(RegSpare, 24'($urandom));
  endtask

  function automatic logic [23:0] rand_coord();
    logic [23:0] w;
    w = 24'($urandom);
    case ($urandom_range(4))
      0: return w;
      1, 2: return 24'($signed(w) >>> $urandom_range(23));
      3: return 24'($signed(24'($urandom_range(8))) - 24'sd4);
      default: begin
        case ($urandom_range(3))
          0: return 24'h7fffff;
          1: return 24'h800000;
          2: return 24'h800001;
          default: return 24'h000000;
        endcase
      end
    endcase
  endfunction

  // coefficient: mostly realistic, sometimes anywhere
  function automatic logic [23:0] rand_coef();
    if ($urandom_range(3) == 0) return 24'($urandom);
    return 24'($signed(24'($urandom)) >>> (4 + $urandom_range(8)));
  endfunction

  task automatic directed_points();
    send_point(24'h000000, 24'h000000);
    send_point(24'h7fffff, 24'h7fffff);
    send_point(24'h800000, 24'h800000);
    send_point(24'h7fffff, 24'h800000);
    send_point(24'h800000, 24'h000000);
    send_point(24'h000000, 24'h7fffff);
    send_point(24'h000001, 24'h000000);
    send_point(24'hffffff, 24'hffffff);
    send_point(24'h100000, 24'h000000);
    send_point(24'h000000, 24'hf00000);
    send_point(24'h555555, 24'haaaaaa);
    send_point(24'haaaaaa, 24'h555555);
    send_point(24'h000003, 24'hfffffd);
    send_point(24'h080000, 24'h080000);
  endtask

  initial begin
    sb = new;
    sb.lens_defaults();
    quiet_cycles = 0;
    idle_pct   = 0;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    start_i    = 1'b0;
    plane_u_i  = '0;
    plane_v_i  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner points under reset lens, zero lens and extreme lenses
    directed_points();
    drain();
    write_lens('0, '0, '0, '0, '0, '0, '0, '0);
    directed_points();
    drain();
    write_lens(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff,
               24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff);
    directed_points();
    drain();
    write_lens(24'h0fffff, 24'h000100, 24'h000000, 24'h0fffff,
               24'h800000, 24'h800000, 24'h800000, 24'h800000);
    directed_points();
    drain();

    // random phases, each under a fresh lens and sender gap rate
    for (int ph = 0; ph < 9; ph++) begin
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 60;
        default: idle_pct = 25;
      endcase
      write_lens(24'($urandom_range(20'hfffff)), 24'($urandom_range(20'hfffff)),
                 24'($urandom), 24'($urandom),
                 rand_coef(), rand_coef(), rand_coef(), rand_coef());
      repeat (115) send_point(rand_coord(), rand_coord());
      drain();
    end

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("fisheye_equidistant_project_tb OK");
    end else begin
      $display("fisheye_equidistant_project_tb NOT OK");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/fep_pkg.sv
hw/rtl/fep_sqrt.sv
hw/rtl/fep_cordic.sv
hw/rtl/fep_poly.sv
hw/rtl/fep_div.sv
hw/rtl/fep_pixel.sv
hw/rtl/fisheye_equidistant_project.sv
hw/rtl/fep_checker.sv
sim/fisheye_equidistant_project_tb.sv
